### design/pstt_pkg.sv
// shared types and constants for the periodic software timer table
// no dependencies; used by periodic_software_timer_table_core
package pstt_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int MAX_FIRES   = 16;

    localparam int SLOT_W   = 4;
    localparam int TIME_W   = 32;
    localparam int ACTION_W = 3;
    localparam int IDX_W    = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W    = $clog2(TIMER_SLOTS + 1);
    localparam int FIRE_W   = $clog2(MAX_FIRES + 1);

    localparam int IN_DATA_W  = ((SLOT_W + 2 * TIME_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((SLOT_W + 7) / 8) * 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK   = 3'd0,
        ACT_INIT   = 3'd1,
        ACT_PERIOD = 3'd2,
        ACT_RUN    = 3'd3,
        ACT_STOP   = 3'd4,
        ACT_UNLIST = 3'd5,
        ACT_RELIST = 3'd6,
        ACT_NONE   = 3'd7
    } action_t;

endpackage

### design/pstt_ram.sv
// generic single write port ram with one registered read port
// no dependencies
module pstt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/periodic_software_timer_table_core.sv
// Periodic timer table. Actions other than tick are taken straight from idle. A tick
// walks the slots through the period and event memories one slot per cycle (one read
// port per memory, registered read), but the walk stalls while a fire waits on a full
// output register. Fires leave in ascending slot order; tlast marks the final fire
// of a tick, and a tick with nothing due sends no result. Memories come up zero
// through per-entry valid bits, so no clearing pass runs after reset.
// depends on pstt_pkg and pstt_ram
module periodic_software_timer_table_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // slot [3:0], period_value [35:4], now [67:36], zero fill above
    input  logic [pstt_pkg::IN_DATA_W-1:0]  s_tdata,
    // action [2:0]
    input  logic [pstt_pkg::ACTION_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // fired_slot [3:0], zero fill above
    output logic [pstt_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                            m_tlast
);

    localparam int IW = pstt_pkg::IDX_W;
    localparam int TW = pstt_pkg::TIME_W;
    localparam int NS = pstt_pkg::TIMER_SLOTS;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t                       state_reg, state_next;
    logic [NS-1:0]                listed_reg, listed_next;
    logic [NS-1:0]                active_reg, active_next;
    logic [NS-1:0]                per_ok_reg, per_ok_next;
    logic [NS-1:0]                ev_ok_reg, ev_ok_next;
    logic [pstt_pkg::CNT_W-1:0]   issue_reg, issue_next;
    logic                         chk_valid_reg, chk_valid_next;
    logic [IW-1:0]                chk_idx_reg, chk_idx_next;
    logic [pstt_pkg::FIRE_W-1:0]  fire_cnt_reg, fire_cnt_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic [IW-1:0]                pend_idx_reg, pend_idx_next;
    logic [TW-1:0]                now_reg, now_next;
    logic                         out_valid_reg, out_valid_next;
    logic [pstt_pkg::SLOT_W-1:0]  out_slot_reg, out_slot_next;
    logic                         out_last_reg, out_last_next;

    logic [pstt_pkg::SLOT_W-1:0]  in_slot;
    logic [TW-1:0]                in_period;
    logic [TW-1:0]                in_now;
    pstt_pkg::action_t            in_action;
    logic                         accept;
    logic                         in_range;
    logic [IW-1:0]                slot_idx;

    logic                         per_we, ev_we;
    logic [IW-1:0]                per_waddr, ev_waddr;
    logic [TW-1:0]                per_wdata, ev_wdata;
    logic [IW-1:0]                raddr;
    logic [TW-1:0]                per_rdata, ev_rdata;

    logic [TW-1:0]                chk_per, chk_ev, elapsed;
    logic                         due, out_free, stall, scan_end;

    assign in_slot   = s_tdata[pstt_pkg::SLOT_W-1:0];
    assign in_period = s_tdata[pstt_pkg::SLOT_W +: TW];
    assign in_now    = s_tdata[pstt_pkg::SLOT_W + TW +: TW];
    assign in_action = pstt_pkg::action_t'(s_tuser);
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign in_range  = 32'(in_slot) < 32'(NS);
    assign slot_idx  = IW'(in_slot);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = pstt_pkg::OUT_DATA_W'(out_slot_reg);
    assign m_tlast  = out_last_reg;

    // scan check stage: memory data for chk_idx_reg arrives this cycle
    assign chk_per  = per_ok_reg[chk_idx_reg] ? per_rdata : '0;
    assign chk_ev   = ev_ok_reg[chk_idx_reg] ? ev_rdata : '0;
    assign elapsed  = now_reg - chk_ev;
    assign due      = (state_reg == ST_SCAN) && chk_valid_reg
                      && listed_reg[chk_idx_reg] && active_reg[chk_idx_reg]
                      && (elapsed >= chk_per)
                      && (fire_cnt_reg < pstt_pkg::FIRE_W'(pstt_pkg::MAX_FIRES));
    assign out_free = !out_valid_reg || m_tready;
    // a new fire pushes the held one out; wait when the output is still full
    assign stall    = due && pend_valid_reg && !out_free;
    assign scan_end = (state_reg == ST_SCAN) && !chk_valid_reg
                      && (issue_reg == pstt_pkg::CNT_W'(NS));

    // on a stall the same entry is read again so its data is there next cycle
    assign raddr = stall ? chk_idx_reg : IW'(issue_reg);

    always_comb
    begin
        per_we    = 1'b0;
        per_waddr = slot_idx;
        per_wdata = '0;
        ev_we     = 1'b0;
        ev_waddr  = slot_idx;
        ev_wdata  = '0;
        if (state_reg == ST_SCAN)
        begin
            ev_we    = due && !stall;
            ev_waddr = chk_idx_reg;
            ev_wdata = now_reg;
        end
        else if (accept && in_range)
        begin
            unique case (in_action)
                pstt_pkg::ACT_INIT:
                begin
                    per_we = 1'b1;
                    ev_we  = 1'b1;
                end
                pstt_pkg::ACT_PERIOD:
                begin
                    per_we    = 1'b1;
                    per_wdata = in_period;
                end
                pstt_pkg::ACT_RUN:
                begin
                    ev_we    = 1'b1;
                    ev_wdata = in_now;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        listed_next     = listed_reg;
        active_next     = active_reg;
        per_ok_next     = per_ok_reg;
        ev_ok_next      = ev_ok_reg;
        issue_next      = issue_reg;
        chk_valid_next  = chk_valid_reg;
        chk_idx_next    = chk_idx_reg;
        fire_cnt_next   = fire_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        now_next        = now_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_slot_next   = out_slot_reg;
        out_last_next   = out_last_reg;

        if (per_we)
        begin
            per_ok_next[per_waddr] = 1'b1;
        end
        if (ev_we)
        begin
            ev_ok_next[ev_waddr] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_action == pstt_pkg::ACT_TICK)
                    begin
                        state_next      = ST_SCAN;
                        now_next        = in_now;
                        issue_next      = '0;
                        chk_valid_next  = 1'b0;
                        fire_cnt_next   = '0;
                        pend_valid_next = 1'b0;
                    end
                    else if (in_range)
                    begin
                        unique case (in_action)
                            pstt_pkg::ACT_INIT:
                            begin
                                active_next[slot_idx] = 1'b0;
                                listed_next[slot_idx] = 1'b1;
                            end
                            pstt_pkg::ACT_RUN:    active_next[slot_idx] = 1'b1;
                            pstt_pkg::ACT_STOP:   active_next[slot_idx] = 1'b0;
                            pstt_pkg::ACT_UNLIST: listed_next[slot_idx] = 1'b0;
                            pstt_pkg::ACT_RELIST: listed_next[slot_idx] = 1'b1;
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            ST_SCAN:
            begin
                if (!stall)
                begin
                    if (issue_reg != pstt_pkg::CNT_W'(NS))
                    begin
                        chk_valid_next = 1'b1;
                        chk_idx_next   = IW'(issue_reg);
                        issue_next     = issue_reg + 1'b1;
                    end
                    else
                    begin
                        chk_valid_next = 1'b0;
                    end
                end
                if (due && !stall)
                begin
                    fire_cnt_next   = fire_cnt_reg + 1'b1;
                    pend_valid_next = 1'b1;
                    pend_idx_next   = chk_idx_reg;
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_slot_next  = pstt_pkg::SLOT_W'(pend_idx_reg);
                        out_last_next  = 1'b0;
                    end
                end
                if (scan_end)
                begin
                    if (!pend_valid_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_slot_next   = pstt_pkg::SLOT_W'(pend_idx_reg);
                        out_last_next   = 1'b1;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            listed_reg     <= '0;
            active_reg     <= '0;
            per_ok_reg     <= '0;
            ev_ok_reg      <= '0;
            issue_reg      <= '0;
            chk_valid_reg  <= 1'b0;
            chk_idx_reg    <= '0;
            fire_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
            now_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_slot_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            listed_reg     <= listed_next;
            active_reg     <= active_next;
            per_ok_reg     <= per_ok_next;
            ev_ok_reg      <= ev_ok_next;
            issue_reg      <= issue_next;
            chk_valid_reg  <= chk_valid_next;
            chk_idx_reg    <= chk_idx_next;
            fire_cnt_reg   <= fire_cnt_next;
            pend_valid_reg <= pend_valid_next;
            pend_idx_reg   <= pend_idx_next;
            now_reg        <= now_next;
            out_valid_reg  <= out_valid_next;
            out_slot_reg   <= out_slot_next;
            out_last_reg   <= out_last_next;
        end
    end

    pstt_ram #(
        .WIDTH (TW),
        .DEPTH (NS)
    ) u_period_ram (
        .clk   (clk),
        .we    (per_we),
        .waddr (per_waddr),
        .wdata (per_wdata),
        .raddr (raddr),
        .rdata (per_rdata)
    );

    pstt_ram #(
        .WIDTH (TW),
        .DEPTH (NS)
    ) u_event_ram (
        .clk   (clk),
        .we    (ev_we),
        .waddr (ev_waddr),
        .wdata (ev_wdata),
        .raddr (raddr),
        .rdata (ev_rdata)
    );

endmodule
